// ----- sv/mfra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfra_pkg
// Shared types and constants of the maximal free rectangle area block.
// ----------------------------------------------------------------------------
package mfra_pkg;

	localparam int CFG_W  = 11;
	localparam int AREA_W = 21;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 24;

	localparam logic [AREA_W-1:0] AREA_LIMIT = 21'h1FFFFF;
	localparam logic [CFG_W-1:0]  COUNT_RESET = 11'd1024;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // zero one height entry
		logic take;       // ready for a cell
		logic height;     // update run height of current column
		logic pop;        // pop stack top into multiplier
		logic pop_load;   // reload top, form area
		logic push;       // push current column
		logic finish;     // close cell, emit on last
	} mfra_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cfg_wr;
		logic clr_done;
		logic in_acc;
		logic pop_hit;
		logic flush_armed;
		logic flush_need;
		logic is_last;
		logic out_free;
	} mfra_sts_t;

endpackage

// ----- sv/maximal_free_rectangle_area.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maximal_free_rectangle_area
// Largest all-free rectangle in a streamed binary matrix.
// ----------------------------------------------------------------------------
// Cells arrive row-major, one per transaction; column_count sets the row
// length and writing it starts a fresh matrix. Each cell passes through
// accept, height memory update and stack check/push, plus a pop and a
// reload for every column popped off the histogram stack, since each pop
// waits on a registered read of the stack memory; the cell that ends a row
// also flushes the stack. Pops never outnumber pushes. The cell with tlast
// set produces the best area on m_tdata. After reset and after every
// column_count write, a clearing pass zeroes all MAX_COLUMNS entries of the
// height memory; after a last cell it zeroes only the active columns. No
// cell is taken during a clearing pass.
// ----------------------------------------------------------------------------
module maximal_free_rectangle_area #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mfra_pkg::CFG_W-1:0]            cfg_data,   // column_count
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mfra_pkg::TDATA_IN_W-1:0]       s_tdata,    // [0] cell_free
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mfra_pkg::TDATA_OUT_W-1:0]      m_tdata     // [20:0] max_area
);
	import mfra_pkg::*;

	mfra_cmd_t         cmd;
	mfra_sts_t         sts;
	logic [AREA_W-1:0] area;

	assign cfg_ready = 1'b1;

	mfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mfra_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_free   (s_tdata[0]),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_area  (area)
	);

	assign m_tdata = {(TDATA_OUT_W - AREA_W)'(0), area};

endmodule

// ----- sv/mfra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfra_ctrl
// Sequencer: height clear pass, per-cell height update, stack pops and
// pushes, row flush and result hand-off.
// ----------------------------------------------------------------------------
module mfra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfra_pkg::mfra_sts_t  sts,
	output mfra_pkg::mfra_cmd_t  cmd
);
	import mfra_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR    = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_HEIGHT   = 6'b000100,
		ST_POP_CHK  = 6'b001000,
		ST_POP_WAIT = 6'b010000,
		ST_FINISH   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_nxt = ST_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_acc) begin
					state_nxt = ST_HEIGHT;
				end
			end
			ST_HEIGHT: begin
				cmd.height = 1'b1;
				state_nxt  = ST_POP_CHK;
			end
			ST_POP_CHK: begin
				priority if (sts.pop_hit) begin
					cmd.pop   = 1'b1;
					state_nxt = ST_POP_WAIT;
				end else if (sts.flush_armed) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.push  = 1'b1;
					state_nxt = sts.flush_need ? ST_POP_CHK : ST_IDLE;
				end
			end
			ST_POP_WAIT: begin
				cmd.pop_load = 1'b1;
				state_nxt    = ST_POP_CHK;
			end
			ST_FINISH: begin
				priority if (!sts.is_last) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_CLEAR;
				end else begin
					state_nxt  = ST_FINISH;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
		if (sts.cfg_wr) begin
			state_nxt = ST_CLEAR;
		end
	end

endmodule

// ----- sv/mfra_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfra_dp
// Datapath: column height memory, histogram stack memory with a top-of-stack
// register, area multiplier, best area and the result register.
// ----------------------------------------------------------------------------
module mfra_dp #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfra_pkg::mfra_cmd_t            cmd,
	output mfra_pkg::mfra_sts_t            sts,
	input  logic                           cfg_valid,
	input  logic [mfra_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_free,
	input  logic                           in_last,
	output logic                           in_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mfra_pkg::AREA_W-1:0]    out_area
);
	import mfra_pkg::*;

	localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int NW  = $clog2(MAX_COLUMNS + 1);
	localparam int HW  = $clog2(MAX_ROWS + 1);
	localparam int EW  = CW + HW;
	localparam int PW  = HW + NW;
	localparam int PXW = (PW > AREA_W) ? PW : AREA_W;

	logic [CFG_W-1:0]  count_q;
	logic [NW-1:0]     act;
	logic [CW-1:0]     pos_q, col_in, col_q;
	logic              free_q, last_q;
	logic [NW-1:0]     clr_q, clr_lim_q;
	logic [HW-1:0]     hmem [MAX_COLUMNS];
	logic [HW-1:0]     hrd_q, h_new, hcur_q, level_q;
	logic              hwe;
	logic [CW-1:0]     hwa;
	logic [HW-1:0]     hwd;
	logic [EW-1:0]     smem [MAX_COLUMNS];
	logic [EW-1:0]     srd_q;
	logic [NW-1:0]     depth_q, sidx;
	logic [HW-1:0]     top_h_q, popped_h_q;
	logic [NW-1:0]     right_q, left, width, col_p1;
	logic [PW-1:0]     prod_s1;
	logic              prod_v_s1;
	logic [PXW-1:0]    prod_x;
	logic [AREA_W-1:0] prod_sat, best_q, area_q;
	logic              flush_armed_q, flush_need, acc, out_v_q;

	always_comb begin
		priority if (count_q == '0) begin
			act = NW'(1);
		end else if (32'(count_q) > 32'(MAX_COLUMNS)) begin
			act = NW'(MAX_COLUMNS);
		end else begin
			act = NW'(count_q);
		end
	end

	assign col_in     = (NW'(pos_q) >= act) ? '0 : pos_q;
	assign col_p1     = NW'(col_q) + NW'(1);
	assign flush_need = (col_p1 >= act) || last_q;
	assign acc        = cmd.take && in_valid;
	assign in_ready   = cmd.take;

	assign h_new = !free_q ? '0 :
		((hrd_q < HW'(MAX_ROWS)) ? hrd_q + HW'(1) : hrd_q);

	// height memory: one write port, one registered read port
	assign hwe = cmd.clr_step || cmd.height;
	assign hwa = cmd.clr_step ? clr_q[CW-1:0] : col_q;
	assign hwd = cmd.clr_step ? '0 : h_new;

	always_ff @(posedge clk) begin
		if (hwe) begin
			hmem[hwa] <= hwd;
		end
		hrd_q <= hmem[col_in];
	end

	// stack memory; the entry below the top is read every cycle
	assign sidx = depth_q - NW'(2);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			smem[depth_q[CW-1:0]] <= {col_q, hcur_q};
		end
		srd_q <= smem[sidx[CW-1:0]];
	end

	assign left   = (depth_q != '0) ? NW'(srd_q[EW-1:HW]) + NW'(1) : '0;
	assign width  = right_q - left;
	assign prod_x = PXW'(prod_s1);
	assign prod_sat = (prod_x > PXW'(AREA_LIMIT)) ? AREA_LIMIT : prod_x[AREA_W-1:0];

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			col_q  <= col_in;
			free_q <= in_free;
			last_q <= in_last;
		end
		if (cmd.height) begin
			hcur_q <= h_new;
		end
		if (cmd.pop) begin
			popped_h_q <= top_h_q;
		end
		if (cmd.pop_load) begin
			prod_s1 <= PW'(popped_h_q) * PW'(width);
			if (depth_q != '0) begin
				top_h_q <= srd_q[HW-1:0];
			end
		end
		if (cmd.push) begin
			top_h_q <= hcur_q;
		end
		if (cmd.finish && last_q) begin
			area_q <= best_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= COUNT_RESET;
			pos_q         <= '0;
			clr_q         <= '0;
			clr_lim_q     <= NW'(MAX_COLUMNS);
			depth_q       <= '0;
			level_q       <= '0;
			right_q       <= '0;
			flush_armed_q <= 1'b0;
			prod_v_s1     <= 1'b0;
			best_q        <= '0;
			out_v_q       <= 1'b0;
		end else begin
			prod_v_s1 <= cmd.pop_load;
			if (prod_v_s1 && (prod_sat > best_q)) begin
				best_q <= prod_sat;
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd.height) begin
				level_q       <= h_new;
				right_q       <= NW'(col_q);
				flush_armed_q <= 1'b0;
			end
			if (cmd.pop) begin
				depth_q <= depth_q - NW'(1);
			end
			if (cmd.push) begin
				depth_q <= depth_q + NW'(1);
				if (flush_need) begin
					level_q       <= '0;
					right_q       <= col_p1;
					flush_armed_q <= 1'b1;
				end else begin
					pos_q <= col_p1[CW-1:0];
				end
			end
			if (cmd.finish) begin
				pos_q <= '0;
				if (last_q) begin
					out_v_q   <= 1'b1;
					best_q    <= '0;
					clr_q     <= '0;
					clr_lim_q <= act;
				end
			end
			if (cfg_valid) begin
				count_q       <= cfg_data;
				pos_q         <= '0;
				depth_q       <= '0;
				best_q        <= '0;
				clr_q         <= '0;
				clr_lim_q     <= NW'(MAX_COLUMNS);
				flush_armed_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_area  = area_q;

	always_comb begin
		sts             = '0;
		sts.cfg_wr      = cfg_valid;
		sts.clr_done    = (clr_q == clr_lim_q);
		sts.in_acc      = acc;
		sts.pop_hit     = (depth_q != '0) && (top_h_q >= level_q);
		sts.flush_armed = flush_armed_q;
		sts.flush_need  = flush_need;
		sts.is_last     = last_q;
		sts.out_free    = !out_v_q || out_ready;
	end

endmodule
